// ===== rtl/core/cdad_pkg.sv =====
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and constants for the date advance core
// field widths, error codes, queue word layout, back-end states, calendar helpers
// ----------------------------------------------------------------------------
package cdad_pkg;

   localparam int YEAR_W = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W = 5;
   localparam int INC_W = 16;
   localparam int ERR_W = 2;
   localparam int CENT_W = 8;
   localparam int YY_W = 7;

   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YY_W-1:0] YY_LAST = 7'd99;

   localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_DATE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   // one classified word as it travels from front to back
   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [CENT_W-1:0] cent;
      logic [YY_W-1:0] yy;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0] day;
      logic [INC_W-1:0] left;
      logic bad;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_FLUSH
   } back_state_type;

   // year mod 4 equals year-in-century mod 4, since 100 is a multiple of 4
   function automatic logic is_leap(input logic [1:0] year_lo, input logic [YY_W-1:0] yy,
                                    input logic [1:0] cent_lo);
      return (year_lo == 2'd0) && ((yy != '0) || (cent_lo == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic leap,
                                                     input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      if (month == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
                   month == MONTH_NOV) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

// ===== rtl/core/cdad_front.sv =====
// ----------------------------------------------------------------------------
// cdad_front: input capture and date classification
// splits the year into century and year-in-century, checks the start date
// ----------------------------------------------------------------------------
module cdad_front #(
   parameter int unsigned INCREMENT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [cdad_pkg::YEAR_W-1:0] req_start_year,
   input  logic [cdad_pkg::MONTH_W-1:0] req_start_month,
   input  logic [cdad_pkg::DAY_W-1:0] req_start_day,
   input  logic [cdad_pkg::INC_W-1:0] req_day_increment,
   output logic push,
   input  logic full,
   output cdad_pkg::item_type push_item
);
   import cdad_pkg::*;

   localparam int USE_BITS = (INCREMENT_BITS < INC_W) ? int'(INCREMENT_BITS) : INC_W;
   localparam logic [INC_W-1:0] INC_MASK = INC_W'((33'h1 << USE_BITS) - 33'h1);
   // floor(y / 100) == (y * 5243) >> 19 for every 14-bit year
   localparam int RECIP_W = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int PROD_W = YEAR_W + RECIP_W;
   localparam int RECIP_SH = 19;

   logic a_valid_ff, a_valid_in;
   logic [YEAR_W-1:0] a_year_ff;
   logic [MONTH_W-1:0] a_month_ff;
   logic [DAY_W-1:0] a_day_ff;
   logic [INC_W-1:0] a_inc_ff;
   logic [PROD_W-1:0] a_prod_ff;
   logic take;

   logic [CENT_W-1:0] cent;
   logic [YEAR_W-1:0] cent_x100;
   logic [YY_W-1:0] yy;
   logic leap;
   logic [DAY_W-1:0] len;
   logic bad;

   assign push = a_valid_ff && !full;
   assign req_stall = a_valid_ff && !push;
   assign take = req_valid && !req_stall;
   assign a_valid_in = take ? 1'b1 : (push ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_year_ff <= req_start_year;
         a_month_ff <= req_start_month;
         a_day_ff <= req_start_day;
         a_inc_ff <= req_day_increment & INC_MASK;
         a_prod_ff <= PROD_W'(req_start_year) * PROD_W'(RECIP_100);
      end
   end

   always_comb begin
      cent = a_prod_ff[RECIP_SH +: CENT_W];
      cent_x100 = YEAR_W'({cent, 6'd0}) + YEAR_W'({cent, 5'd0}) + YEAR_W'({cent, 2'd0});
      yy = YY_W'(a_year_ff - cent_x100);
      leap = is_leap(a_year_ff[1:0], yy, cent[1:0]);
      len = month_length(leap, a_month_ff);
      bad = (a_year_ff == '0) || (a_year_ff > YEAR_MAX) ||
            (a_month_ff == '0) || (a_month_ff > MONTH_DEC) ||
            (a_day_ff == '0) || (a_day_ff > len);
   end

   // whole 400-year cycles (146097 days) never fit in the increment field
   always_comb begin
      push_item.year = a_year_ff;
      push_item.cent = cent;
      push_item.yy = yy;
      push_item.month = a_month_ff;
      push_item.day = a_day_ff;
      push_item.left = bad ? '0 : a_inc_ff;
      push_item.bad = bad;
   end

endmodule

// ===== rtl/core/cdad_queue.sv =====
// ----------------------------------------------------------------------------
// cdad_queue: two-entry queue between front and back
// lets the front keep classifying while the back walks months
// ----------------------------------------------------------------------------
module cdad_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cdad_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output cdad_pkg::item_type pop_item
);
   import cdad_pkg::*;

   item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/cdad_back.sv =====
// ----------------------------------------------------------------------------
// cdad_back: month walker and result register
// steps one month per cycle, then hands the date to the output register
// ----------------------------------------------------------------------------
module cdad_back (
   input  logic clock,
   input  logic reset,
   input  logic not_empty,
   input  cdad_pkg::item_type pop_item,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [cdad_pkg::YEAR_W-1:0] rsp_result_year,
   output logic [cdad_pkg::MONTH_W-1:0] rsp_result_month,
   output logic [cdad_pkg::DAY_W-1:0] rsp_result_day,
   output logic [cdad_pkg::ERR_W-1:0] rsp_error_code
);
   import cdad_pkg::*;

   back_state_type state_ff, state_in;

   logic [YEAR_W-1:0] year_ff;
   logic [CENT_W-1:0] cent_ff;
   logic [YY_W-1:0] yy_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0] day_ff;
   logic [INC_W-1:0] left_ff;
   logic bad_ff;

   logic out_valid_ff, out_valid_in;
   logic [YEAR_W-1:0] out_year_ff;
   logic [MONTH_W-1:0] out_month_ff;
   logic [DAY_W-1:0] out_day_ff;
   logic [ERR_W-1:0] out_err_ff;

   logic load, step, out_load, out_free;
   logic leap, fits;
   logic [DAY_W-1:0] len;
   logic [INC_W:0] sum;
   logic [DAY_W:0] skip;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (not_empty) begin
               state_in = BK_WALK;
            end
         end
         BK_WALK: begin
            if (left_ff == '0) begin
               state_in = BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      load = 1'b0;
      step = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: load = not_empty;
         BK_WALK: step = (left_ff != '0);
         BK_FLUSH: out_load = out_free;
         default: ;
      endcase
   end

   assign pop = load;

   always_comb begin
      leap = is_leap(year_ff[1:0], yy_ff, cent_ff[1:0]);
      len = month_length(leap, month_ff);
      sum = (INC_W+1)'(day_ff) + (INC_W+1)'(left_ff);
      fits = (sum <= (INC_W+1)'(len));
      skip = (DAY_W+1)'(len) - (DAY_W+1)'(day_ff) + 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         year_ff <= pop_item.year;
         cent_ff <= pop_item.cent;
         yy_ff <= pop_item.yy;
         month_ff <= pop_item.month;
         day_ff <= pop_item.day;
         left_ff <= pop_item.left;
         bad_ff <= pop_item.bad;
      end else if (step) begin
         if (fits) begin
            day_ff <= sum[DAY_W-1:0];
            left_ff <= '0;
         end else begin
            day_ff <= 5'd1;
            left_ff <= left_ff - INC_W'(skip);
            if (month_ff == MONTH_DEC) begin
               month_ff <= MONTH_JAN;
               year_ff <= year_ff + 14'd1;
               if (yy_ff == YY_LAST) begin
                  yy_ff <= '0;
                  cent_ff <= cent_ff + 8'd1;
               end else begin
                  yy_ff <= yy_ff + 7'd1;
               end
            end else begin
               month_ff <= month_ff + 4'd1;
            end
         end
      end
   end

   assign out_valid_in = out_load ? 1'b1 : ((out_valid_ff && rsp_stall) ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (bad_ff) begin
            out_year_ff <= '0;
            out_month_ff <= '0;
            out_day_ff <= '0;
            out_err_ff <= ERR_BAD_DATE;
         end else begin
            out_year_ff <= year_ff;
            out_month_ff <= month_ff;
            out_day_ff <= day_ff;
            out_err_ff <= (year_ff > YEAR_MAX) ? ERR_OVERFLOW : ERR_OK;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_year = out_year_ff;
   assign rsp_result_month = out_month_ff;
   assign rsp_result_day = out_day_ff;
   assign rsp_error_code = out_err_ff;

endmodule

// ===== rtl/core/calendar_date_add_days_core.sv =====
// ----------------------------------------------------------------------------
// calendar_date_add_days_core: gregorian date plus a day count
// front classifies the start date, back walks it forward one month per cycle
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  start year, month, day, increment
//   rsp_     out        rsp_valid/rsp_stall  result year, month, day, error code
//
// a word passes the front register, the queue, the month walker in the back end,
//   which steps one month per cycle, and the output register on its way to rsp_valid
// the front can hold one word and the queue two more while the back walks
// reset is synchronous and clears only control state; no clearing pass
// rsp_stall holds the result register, which backs up into the queue
// ----------------------------------------------------------------------------
module calendar_date_add_days_core #(
   parameter int unsigned INCREMENT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [cdad_pkg::YEAR_W-1:0] req_start_year,
   input  logic [cdad_pkg::MONTH_W-1:0] req_start_month,
   input  logic [cdad_pkg::DAY_W-1:0] req_start_day,
   input  logic [cdad_pkg::INC_W-1:0] req_day_increment,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [cdad_pkg::YEAR_W-1:0] rsp_result_year,
   output logic [cdad_pkg::MONTH_W-1:0] rsp_result_month,
   output logic [cdad_pkg::DAY_W-1:0] rsp_result_day,
   output logic [cdad_pkg::ERR_W-1:0] rsp_error_code
);
   import cdad_pkg::*;

   // front to queue
   logic push, full;
   item_type push_item;
   // queue to back
   logic pop, not_empty;
   item_type pop_item;

   // capture, century split, validity check
   cdad_front #(
      .INCREMENT_BITS(INCREMENT_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_year(req_start_year),
      .req_start_month(req_start_month),
      .req_start_day(req_start_day),
      .req_day_increment(req_day_increment),
      .push(push),
      .full(full),
      .push_item(push_item)
   );

   // decoupling queue
   cdad_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .full(full),
      .pop(pop),
      .not_empty(not_empty),
      .pop_item(pop_item)
   );

   // month walker and output register
   cdad_back u_back (
      .clock(clock),
      .reset(reset),
      .not_empty(not_empty),
      .pop_item(pop_item),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_year(rsp_result_year),
      .rsp_result_month(rsp_result_month),
      .rsp_result_day(rsp_result_day),
      .rsp_error_code(rsp_error_code)
   );

   // a bad start date reports all-zero date fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_BAD_DATE) |->
         (rsp_result_year == '0 && rsp_result_month == '0 && rsp_result_day == '0))
      else $error("bad-date word carries nonzero date");

   // a clean result is a real calendar position
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_OK) |->
         (rsp_result_month != '0 && rsp_result_month <= MONTH_DEC &&
          rsp_result_day != '0 && rsp_result_year != '0 && rsp_result_year <= YEAR_MAX))
      else $error("ok word out of calendar range");

   // overflow is flagged only for years past the limit
   a_ovf_year: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_OVERFLOW) |-> (rsp_result_year > YEAR_MAX))
      else $error("overflow flagged on an in-range year");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for calendar_date_add_days_core
// drives start dates and day counts, walks each untyped date forward in
// a local calendar model (typed rows carry their answer) and compares
// every result word field by field, in order
module tb;
   import cdad_pkg::*;

   localparam int INC_BITS = 16;
   localparam int unsigned DAYS_PER_400Y = 146097;
   localparam int RANDOM_WORDS = 250;
   localparam int HOLD_AFTER = 60;        // result count that starts the long hold
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 20000;

   // one start date with its day count, as the request channel carries it
   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0] day;
      logic [INC_W-1:0] incr;
   } start_word_type;

   // one advanced date, as the response channel carries it
   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0] day;
      logic [ERR_W-1:0] err;
   } date_result_type;

   // directed row: typed rows carry the answer, the rest go to the calendar model
   typedef struct packed {
      start_word_type start;
      logic typed;
      date_result_type answer;
   } date_row_type;

   typedef enum int {
      FLAW_YEAR_ZERO,
      FLAW_YEAR_HIGH,
      FLAW_MONTH_ZERO,
      FLAW_MONTH_HIGH,
      FLAW_DAY_ZERO,
      FLAW_DAY_PAST_END
   } flaw_kind_type;

   localparam date_result_type NO_ANSWER = '0;
   localparam date_result_type BAD_DATE = '{'0, '0, '0, ERR_BAD_DATE};

   localparam date_row_type DIRECTED_ROWS [25] = '{
      // zero increment straight after reset returns the start date
      '{'{2024, 1, 15, 0}, 1'b1, '{2024, 1, 15, ERR_OK}},
      // broken start dates: year, month and day out of range, and valid leap days
      '{'{0, 1, 1, 5}, 1'b1, BAD_DATE},
      '{'{10000, 6, 15, 0}, 1'b1, BAD_DATE},
      '{'{16383, 15, 31, 65535}, 1'b1, BAD_DATE},
      '{'{2023, 2, 29, 1}, 1'b1, BAD_DATE},
      '{'{1900, 2, 29, 0}, 1'b1, BAD_DATE},
      '{'{2000, 2, 29, 0}, 1'b1, '{2000, 2, 29, ERR_OK}},
      '{'{2024, 2, 29, 1}, 1'b1, '{2024, 3, 1, ERR_OK}},
      '{'{2023, 4, 31, 0}, 1'b1, BAD_DATE},
      '{'{2023, 0, 10, 3}, 1'b1, BAD_DATE},
      '{'{2023, 13, 1, 0}, 1'b1, BAD_DATE},
      '{'{2023, 5, 0, 7}, 1'b1, BAD_DATE},
      // last representable day, then one past it, then single-day steps
      '{'{9999, 12, 31, 0}, 1'b1, '{9999, 12, 31, ERR_OK}},
      '{'{9999, 12, 31, 1}, 1'b1, '{10000, 1, 1, ERR_OVERFLOW}},
      '{'{1, 1, 1, 1}, 1'b1, '{1, 1, 2, ERR_OK}},
      '{'{2023, 12, 31, 1}, 1'b1, '{2024, 1, 1, ERR_OK}},
      // longest walks and leap corners, answered by the model
      '{'{1, 1, 1, 65535}, 1'b0, NO_ANSWER},
      '{'{9999, 12, 31, 65535}, 1'b0, NO_ANSWER},
      '{'{2023, 1, 31, 29}, 1'b0, NO_ANSWER},
      '{'{2100, 2, 28, 1}, 1'b0, NO_ANSWER},
      '{'{2399, 12, 31, 366}, 1'b0, NO_ANSWER},
      // alternating bit patterns in every field, then further long walks
      '{'{5461, 10, 21, 21845}, 1'b0, NO_ANSWER},
      '{'{10922, 5, 10, 43690}, 1'b0, NO_ANSWER},
      '{'{9818, 3, 1, 65535}, 1'b0, NO_ANSWER},
      '{'{2024, 6, 30, 32768}, 1'b0, NO_ANSWER}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [YEAR_W-1:0] req_start_year = '0;
   logic [MONTH_W-1:0] req_start_month = '0;
   logic [DAY_W-1:0] req_start_day = '0;
   logic [INC_W-1:0] req_day_increment = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [YEAR_W-1:0] rsp_result_year;
   logic [MONTH_W-1:0] rsp_result_month;
   logic [DAY_W-1:0] rsp_result_day;
   logic [ERR_W-1:0] rsp_error_code;

   // answer of a typed row travels beside the request word it belongs to
   logic row_typed = 1'b0;
   date_result_type row_answer = '0;

   date_result_type pending_dates [$];
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int send_calm = 0;
   int recv_calm = 0;

   always #6 clock = ~clock;

   calendar_date_add_days_core #(
      .INCREMENT_BITS(INC_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_year(req_start_year),
      .req_start_month(req_start_month),
      .req_start_day(req_start_day),
      .req_day_increment(req_day_increment),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_year(rsp_result_year),
      .rsp_result_month(rsp_result_month),
      .rsp_result_day(rsp_result_day),
      .rsp_error_code(rsp_error_code)
   );

   // gregorian month length, leap by the 4/100/400 rule of the year walked through
   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      logic leap;
      leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
      if (m == MONTH_FEB) return leap ? 29 : 28;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
      return 31;
   endfunction

   // walk the start date forward month by month, as the core does
   function automatic date_result_type advance_date(input start_word_type w);
      date_result_type r;
      int unsigned y, m, d, len;
      longint unsigned n;
      y = w.year;
      m = w.month;
      d = w.day;
      n = longint'(w.incr) & ((64'd1 << INC_BITS) - 64'd1);
      if (y == 0 || y > YEAR_MAX || m == 0 || m > MONTH_DEC || d == 0 ||
          d > days_in_month(y, m)) begin
         return BAD_DATE;
      end
      // whole 400-year cycles leave month and day alone
      y += (n / DAYS_PER_400Y) * 400;
      n %= DAYS_PER_400Y;
      while (n > 0) begin
         len = days_in_month(y, m);
         if (d + n <= len) begin
            d += n;
            n = 0;
         end else begin
            n -= len - d + 1;
            d = 1;
            m++;
            if (m > MONTH_DEC) begin
               m = MONTH_JAN;
               y++;
            end
         end
      end
      r.year = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day = DAY_W'(d);
      r.err = (y > YEAR_MAX) ? ERR_OVERFLOW : ERR_OK;
      return r;
   endfunction

   // wait before the next word: mostly a random gap, with runs of back-to-back words
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // mostly valid dates with years near the top and century years over-weighted,
   // short walks common, full-range walks rarer; a tenth carry a broken date
   function automatic start_word_type random_word();
      start_word_type w;
      int unsigned len, pick;
      flaw_kind_type flaw;
      pick = $urandom_range(0, 19);
      if (pick < 3) w.year = $urandom_range(9800, 9999);
      else if (pick < 6) w.year = 100 * $urandom_range(1, 99);
      else w.year = $urandom_range(1, 9999);
      w.month = $urandom_range(1, 12);
      len = days_in_month(w.year, w.month);
      w.day = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
      pick = $urandom_range(0, 19);
      if (pick < 12) w.incr = $urandom_range(0, 63);
      else if (pick < 17) w.incr = $urandom_range(0, 4095);
      else w.incr = $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) begin
         flaw = flaw_kind_type'($urandom_range(0, 5));
         case (flaw)
            FLAW_YEAR_ZERO: w.year = '0;
            FLAW_YEAR_HIGH: w.year = $urandom_range(10000, 16383);
            FLAW_MONTH_ZERO: w.month = '0;
            FLAW_MONTH_HIGH: w.month = $urandom_range(13, 15);
            FLAW_DAY_ZERO: w.day = '0;
            default: begin
               if (len < 31) w.day = $urandom_range(len + 1, 31);
               else w.day = '0;
            end
         endcase
      end
      return w;
   endfunction

   // offer one word after a random gap; valid stays up between back-to-back words
   task automatic offer_word(input start_word_type w, input logic typed,
                             input date_result_type ans);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_year <= w.year;
      req_start_month <= w.month;
      req_start_day <= w.day;
      req_day_increment <= w.incr;
      row_typed <= typed;
      row_answer <= ans;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: random stall before each word, and once a long hold-off
   // so the front and the queue fill up and the core stalls its input
   initial begin : receiver
      int wait_cycles, taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = draw_wait(recv_calm);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken == HOLD_AFTER) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   // scoreboard: queue the expected date on each accepted request word,
   // check each accepted response word against the oldest one
   always @(posedge clock) begin : scoreboard
      start_word_type seen;
      date_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen = '{req_start_year, req_start_month, req_start_day, req_day_increment};
            pending_dates.push_back(row_typed ? row_answer : advance_date(seen));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_dates.size() == 0) begin
               $error("response word with no date pending: %0d-%0d-%0d err %0d",
                      rsp_result_year, rsp_result_month, rsp_result_day, rsp_error_code);
               mismatch_count++;
            end else begin
               want = pending_dates.pop_front();
               if (rsp_result_year !== want.year) begin
                  $error("result_year: expected %0d, actual %0d", want.year, rsp_result_year);
                  mismatch_count++;
               end
               if (rsp_result_month !== want.month) begin
                  $error("result_month: expected %0d, actual %0d", want.month,
                         rsp_result_month);
                  mismatch_count++;
               end
               if (rsp_result_day !== want.day) begin
                  $error("result_day: expected %0d, actual %0d", want.day, rsp_result_day);
                  mismatch_count++;
               end
               if (rsp_error_code !== want.err) begin
                  $error("error_code: expected %0d, actual %0d", want.err, rsp_error_code);
                  mismatch_count++;
               end
            end
         end
         // watchdog: nothing moving on either channel for too long
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed table first, then the random words
      foreach (DIRECTED_ROWS[r]) begin
         offer_word(DIRECTED_ROWS[r].start, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].answer);
      end
      for (i = 0; i < RANDOM_WORDS; i++) begin
         offer_word(random_word(), 1'b0, NO_ANSWER);
      end
      req_valid <= 1'b0;
      // drain, then give any stray word time to show up
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
